FILE: sv/potb_pkg.sv
`default_nettype none

package potb_pkg;

    localparam int TIMERS = 16;
    localparam int SLOT_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int PTR_W  = SLOT_W + 1;

    // field widths of the channel words
    localparam int MODE_W  = 2;
    localparam int ID_W    = 4;
    localparam int TASK_W  = 8;
    localparam int SIG_W   = 8;
    localparam int TICKS_W = 32;

    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

    typedef logic [SLOT_W-1:0] slot_t;
    // top bit set marks the null pointer
    typedef logic [PTR_W-1:0]  ptr_t;
    localparam ptr_t NIL_PTR = ptr_t'(1) << SLOT_W;

    typedef struct packed {
        logic [TICKS_W-1:0] count;
        logic [TICKS_W-1:0] reload;
        logic [TASK_W-1:0]  owner;
        logic [SIG_W-1:0]   sig;
    } rec_t;

    typedef struct packed {
        logic [ID_W-1:0]   slot;
        logic [TASK_W-1:0] owner;
        logic [SIG_W-1:0]  sig;
    } fire_rec_t;

    typedef struct packed {
        logic      fire;
        logic      flush;
        fire_rec_t rec;
    } fire_cmd_t;

    typedef struct packed {
        logic fire_ready;
        logic flush_done;
    } fire_sts_t;

endpackage

`default_nettype wire

FILE: sv/potb_if.sv
`default_nettype none

interface potb_in_if import potb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [ID_W-1:0]    timer_id;
    logic [TASK_W-1:0]  task_id;
    logic [SIG_W-1:0]   signal_id;
    logic [TICKS_W-1:0] period;
    logic [TICKS_W-1:0] first_delay;

    modport source (output valid, mode, timer_id, task_id, signal_id, period, first_delay,
                    input ready);
    modport sink (input valid, mode, timer_id, task_id, signal_id, period, first_delay,
                  output ready);
endinterface

interface potb_out_if import potb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   fired_slot;
    logic [TASK_W-1:0] target_task;
    logic [SIG_W-1:0]  fired_signal;
    logic              last;

    modport source (output valid, fired_slot, target_task, fired_signal, last,
                    input ready);
    modport sink (input valid, fired_slot, target_task, fired_signal, last,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/potb_fire_stage.sv
`default_nettype none

module potb_fire_stage import potb_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire fire_cmd_t ctl,
    output fire_sts_t      sts,
    potb_out_if.source     alarm
);

    logic      out_v_reg;
    logic      out_last_reg;
    fire_rec_t out_rec_reg;
    logic      pend_v_reg;
    fire_rec_t pend_rec_reg;
    logic      out_free;

    assign out_free       = !out_v_reg || alarm.ready;
    assign sts.fire_ready = !pend_v_reg || out_free;
    assign sts.flush_done = !pend_v_reg || out_free;

    // hold one fire back until the walk shows whether it is the last of the tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            pend_v_reg <= 1'b0;
        end
        else
        begin
            if (ctl.fire && sts.fire_ready)
            begin
                if (pend_v_reg)
                    out_v_reg <= 1'b1;
                else if (alarm.ready)
                    out_v_reg <= 1'b0;
                pend_v_reg <= 1'b1;
            end
            else if (ctl.flush && pend_v_reg && out_free)
            begin
                out_v_reg  <= 1'b1;
                pend_v_reg <= 1'b0;
            end
            else if (alarm.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fire && sts.fire_ready)
        begin
            pend_rec_reg <= ctl.rec;
            if (pend_v_reg)
            begin
                out_rec_reg  <= pend_rec_reg;
                out_last_reg <= 1'b0;
            end
        end
        else if (ctl.flush && pend_v_reg && out_free)
        begin
            out_rec_reg  <= pend_rec_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign alarm.valid        = out_v_reg;
    assign alarm.fired_slot   = out_rec_reg.slot;
    assign alarm.target_task  = out_rec_reg.owner;
    assign alarm.fired_signal = out_rec_reg.sig;
    assign alarm.last         = out_last_reg;

endmodule

`default_nettype wire

FILE: sv/periodic_oneshot_timer_bank.sv
// Tick: one slot per cycle unless the fire stage stalls; an empty list returns to idle
//   without a walk. Fire words leave through a hold and output register.
// Start: written while idle, then appended; a listed slot is unlinked first. Stop of a
//   listed slot: unlinked by a walk over the next-pointer memory; other words are dropped.
// Reset: list empty, all slots idle. Slot memories keep no reset and need no
//   clearing pass; entries are read only after a start has written them.
`default_nettype none

module periodic_oneshot_timer_bank import potb_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    potb_in_if.sink    cmd,
    potb_out_if.source alarm
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WALK   = 3'd1;
    localparam logic [2:0] ST_FLUSH  = 3'd2;
    localparam logic [2:0] ST_UNL_S  = 3'd3;
    localparam logic [2:0] ST_UNL_W  = 3'd4;
    localparam logic [2:0] ST_APPEND = 3'd5;

    logic [2:0]        state_reg, state_next;
    ptr_t              head_reg, head_next;
    ptr_t              tail_reg, tail_next;
    slot_t             cur_reg, cur_next;
    slot_t             sel_reg, sel_next;
    ptr_t              snext_reg, snext_next;
    logic              is_start_reg, is_start_next;
    logic [TIMERS-1:0] running_reg, running_next;
    logic [TIMERS-1:0] linked_reg, linked_next;

    rec_t  rec_mem [TIMERS];
    ptr_t  nx_mem [TIMERS];
    rec_t  rec_rd_reg;
    ptr_t  nx_rd_reg;

    logic  rd_en;
    slot_t rd_addr;
    logic  rec_we;
    slot_t rec_wa;
    rec_t  rec_wd;
    logic  nx_we;
    slot_t nx_wa;
    ptr_t  nx_wd;

    fire_cmd_t fire_ctl;
    fire_sts_t fire_sts;

    slot_t cmd_slot;
    logic  cmd_id_ok;
    ptr_t  cur_ptr;
    ptr_t  sel_ptr;
    logic  walk_dec;
    logic  walk_fire;

    assign cmd_slot  = SLOT_W'(cmd.timer_id);
    assign cmd_id_ok = 32'(cmd.timer_id) < TIMERS;
    assign cur_ptr   = {1'b0, cur_reg};
    assign sel_ptr   = {1'b0, sel_reg};
    assign walk_dec  = running_reg[cur_reg] && (rec_rd_reg.count != '0);
    assign walk_fire = running_reg[cur_reg] && (rec_rd_reg.count == TICKS_W'(1));

    assign cmd.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (rec_we)
            rec_mem[rec_wa] <= rec_wd;
        if (nx_we)
            nx_mem[nx_wa] <= nx_wd;
        if (rd_en)
        begin
            rec_rd_reg <= rec_mem[rd_addr];
            nx_rd_reg  <= nx_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        cur_next      = cur_reg;
        sel_next      = sel_reg;
        snext_next    = snext_reg;
        is_start_next = is_start_reg;
        running_next  = running_reg;
        linked_next   = linked_reg;
        rd_en         = 1'b0;
        rd_addr       = cur_reg;
        rec_we        = 1'b0;
        rec_wa        = cur_reg;
        rec_wd        = rec_rd_reg;
        nx_we         = 1'b0;
        nx_wa         = cur_reg;
        nx_wd         = snext_reg;
        fire_ctl.fire      = 1'b0;
        fire_ctl.flush     = 1'b0;
        fire_ctl.rec.slot  = ID_W'(cur_reg);
        fire_ctl.rec.owner = rec_rd_reg.owner;
        fire_ctl.rec.sig   = rec_rd_reg.sig;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.mode == MODE_TICK)
                    begin
                        if (!head_reg[PTR_W-1])
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg[SLOT_W-1:0];
                            cur_next   = head_reg[SLOT_W-1:0];
                            state_next = ST_WALK;
                        end
                    end
                    else if (cmd.mode == MODE_START && cmd_id_ok && cmd.first_delay != '0)
                    begin
                        rec_we                 = 1'b1;
                        rec_wa                 = cmd_slot;
                        rec_wd.count           = cmd.first_delay;
                        rec_wd.reload          = cmd.period;
                        rec_wd.owner           = cmd.task_id;
                        rec_wd.sig             = cmd.signal_id;
                        running_next[cmd_slot] = 1'b1;
                        sel_next               = cmd_slot;
                        is_start_next          = 1'b1;
                        if (linked_reg[cmd_slot])
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = cmd_slot;
                            state_next = ST_UNL_S;
                        end
                        else
                        begin
                            state_next = ST_APPEND;
                        end
                    end
                    else if (cmd.mode == MODE_STOP && cmd_id_ok && linked_reg[cmd_slot])
                    begin
                        running_next[cmd_slot] = 1'b0;
                        sel_next               = cmd_slot;
                        is_start_next          = 1'b0;
                        rd_en                  = 1'b1;
                        rd_addr                = cmd_slot;
                        state_next             = ST_UNL_S;
                    end
                end
            end

            ST_WALK:
            begin
                fire_ctl.fire = walk_fire;
                if (!walk_fire || fire_sts.fire_ready)
                begin
                    rec_we       = walk_dec;
                    rec_wa       = cur_reg;
                    rec_wd.count = walk_fire ? rec_rd_reg.reload
                                             : rec_rd_reg.count - TICKS_W'(1);
                    // one-shot expiry: go idle but stay listed
                    if (walk_fire && rec_rd_reg.reload == '0)
                        running_next[cur_reg] = 1'b0;
                    if (cur_ptr == tail_reg)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = nx_rd_reg[SLOT_W-1:0];
                        cur_next = nx_rd_reg[SLOT_W-1:0];
                    end
                end
            end

            ST_FLUSH:
            begin
                fire_ctl.flush = 1'b1;
                if (fire_sts.flush_done)
                    state_next = ST_IDLE;
            end

            ST_UNL_S:
            begin
                snext_next = nx_rd_reg;
                if (head_reg == sel_ptr)
                begin
                    if (tail_reg == sel_ptr)
                    begin
                        head_next = NIL_PTR;
                        tail_next = NIL_PTR;
                    end
                    else
                    begin
                        head_next = nx_rd_reg;
                    end
                    linked_next[sel_reg] = 1'b0;
                    state_next           = is_start_reg ? ST_APPEND : ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = head_reg[SLOT_W-1:0];
                    cur_next   = head_reg[SLOT_W-1:0];
                    state_next = ST_UNL_W;
                end
            end

            ST_UNL_W:
            begin
                if (nx_rd_reg == sel_ptr)
                begin
                    // bridge the predecessor over the removed slot
                    nx_we = 1'b1;
                    nx_wa = cur_reg;
                    nx_wd = snext_reg;
                    if (tail_reg == sel_ptr)
                        tail_next = cur_ptr;
                    linked_next[sel_reg] = 1'b0;
                    state_next           = is_start_reg ? ST_APPEND : ST_IDLE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = nx_rd_reg[SLOT_W-1:0];
                    cur_next = nx_rd_reg[SLOT_W-1:0];
                end
            end

            ST_APPEND:
            begin
                if (head_reg[PTR_W-1])
                begin
                    head_next = sel_ptr;
                end
                else
                begin
                    nx_we = 1'b1;
                    nx_wa = tail_reg[SLOT_W-1:0];
                    nx_wd = sel_ptr;
                end
                tail_next            = sel_ptr;
                linked_next[sel_reg] = 1'b1;
                state_next           = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= NIL_PTR;
            tail_reg     <= NIL_PTR;
            running_reg  <= '0;
            linked_reg   <= '0;
            is_start_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            running_reg  <= running_next;
            linked_reg   <= linked_next;
            is_start_reg <= is_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        sel_reg   <= sel_next;
        snext_reg <= snext_next;
    end

    potb_fire_stage u_fire_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (fire_ctl),
        .sts   (fire_sts),
        .alarm (alarm)
    );

    a_head_tail_null: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg[PTR_W-1] == tail_reg[PTR_W-1])
        else $error("list head and tail disagree on an empty list");

    a_tail_linked: assert property (@(posedge clk) disable iff (!rst_n)
        !tail_reg[PTR_W-1] |-> linked_reg[tail_reg[SLOT_W-1:0]])
        else $error("list tail points at an unlinked slot");

    a_walk_linked: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> linked_reg[cur_reg])
        else $error("tick walk visits an unlinked slot");

endmodule

`default_nettype wire
